// File: rtl/sacfl_pkg.sv
// Shared types and constants for the set-associative FIFO-replacement cache lookup.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sacfl_pkg;

  localparam int unsigned DEF_MAX_SET_COUNT = 128;
  localparam int unsigned DEF_MAX_WAYS      = 8;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned BB_W       = 16;
  localparam int unsigned SC_W       = 8;
  localparam int unsigned WAYS_CFG_W = 4;
  localparam int unsigned SET_OUT_W  = 7;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BYTES = 2'd0,
    CFG_SET_COUNT   = 2'd1,
    CFG_WAYS        = 2'd2
  } cfg_idx_e;

  // One classified lookup travelling from front to back.
  typedef struct packed {
    logic [SC_W-1:0]  set;
    logic [TAG_W-1:0] tag;
  } sacfl_req_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_BLOCK,
    F_SET,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_FILL,
    B_TAG_RD,
    B_TAG_CMP,
    B_SHIFT_RD,
    B_SHIFT_WR,
    B_WRITE,
    B_DONE
  } back_state_e;

endpackage

`default_nettype wire

// File: rtl/set_assoc_cache_fifo_lookup_core.sv
// Top level of the set-associative cache lookup with FIFO replacement.
// Uses sacfl_pkg, sacfl_front, sacfl_queue and sacfl_back.
`default_nettype none

// Usage: one byte address per item, taken when start_i is high and busy_o is
// low. The address is divided by block_bytes, the remainder of that block
// number by set_count picks the set, and the quotient is the tag. Each item
// gives exactly one result, shown for a single cycle with valid_o high; the
// receiver cannot stall it, so it must take every result as it appears.
// Flow: the front end runs both divisions on one shared radix-2 divider and
// stays busy until its item is pushed into the queue, so it takes one item at
// a time; that divider sets the sustained rate. The back end walks the set in
// the tag store, reading and comparing one way after another and, on an
// eviction, reading and rewriting each later way one place down, and overlaps
// the next item's division through a two-entry queue.
// After reset the per-set fill counts are cleared, one set per cycle, over all
// MAX_SET_COUNT sets; busy_o stays high during that pass.
// Configuration: registers block_bytes (index 0), set_count (1) and ways (2)
// are written on the cfg port, which is always ready; write them only while
// the block is idle. Zero values act as 1, and set_count and ways above
// MAX_SET_COUNT and MAX_WAYS act as those bounds. Other indexes are ignored.
// Cache contents and totals survive configuration writes.

module set_assoc_cache_fifo_lookup_core import sacfl_pkg::*; #(
  parameter int unsigned MAX_SET_COUNT = DEF_MAX_SET_COUNT,
  parameter int unsigned MAX_WAYS      = DEF_MAX_WAYS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [ADDR_W-1:0]     address_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       valid_o,
  output logic                       hit_o,
  output logic [SET_OUT_W-1:0]       set_index_o,
  output logic [TAG_W-1:0]           tag_o,
  output logic                       evicted_o,
  output logic [TAG_W-1:0]           evicted_tag_o,
  output logic [CNT_W-1:0]           hit_total_o,
  output logic [CNT_W-1:0]           miss_total_o
);

  localparam int unsigned FILL_W = $clog2(MAX_WAYS + 1);

  // raw register values, clamped below
  logic [BB_W-1:0]       block_bytes_q;
  logic [SC_W-1:0]       set_count_q;
  logic [WAYS_CFG_W-1:0] ways_q;

  logic [BB_W-1:0]   bb_eff;
  logic [SC_W-1:0]   sc_eff;
  logic [FILL_W-1:0] nw_eff;

  logic       accept;
  logic       front_busy;
  logic       clearing;
  logic       push;
  sacfl_req_t push_req;
  sacfl_req_t pop_req;
  logic       q_full;
  logic       q_empty;
  logic       pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BB_W'(1);
      set_count_q   <= SC_W'(1);
      ways_q        <= WAYS_CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BLOCK_BYTES: block_bytes_q <= cfg_data_i[BB_W-1:0];
        CFG_SET_COUNT:   set_count_q   <= cfg_data_i[SC_W-1:0];
        CFG_WAYS:        ways_q        <= cfg_data_i[WAYS_CFG_W-1:0];
        default:         ways_q        <= ways_q;  // unused index
      endcase
    end
  end

  always_comb begin
    bb_eff = (block_bytes_q == '0) ? BB_W'(1) : block_bytes_q;

    if (set_count_q == '0) begin
      sc_eff = SC_W'(1);
    end else if (32'(set_count_q) > MAX_SET_COUNT) begin
      sc_eff = SC_W'(MAX_SET_COUNT);
    end else begin
      sc_eff = set_count_q;
    end

    if (ways_q == '0) begin
      nw_eff = FILL_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      nw_eff = FILL_W'(MAX_WAYS);
    end else begin
      nw_eff = FILL_W'(ways_q);
    end
  end

  // front is one item at a time; the clearing pass also holds off items
  assign busy_o = front_busy | clearing;
  assign accept = start_i & ~busy_o;

  sacfl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .address_i     (address_i),
    .block_bytes_i (bb_eff),
    .set_count_i   (sc_eff),
    .q_full_i      (q_full),
    .busy_o        (front_busy),
    .push_o        (push),
    .req_o         (push_req)
  );

  sacfl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_req),
    .pop_i       (pop),
    .pop_data_o  (pop_req),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  sacfl_back #(
    .MAX_SET_COUNT (MAX_SET_COUNT),
    .MAX_WAYS      (MAX_WAYS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nw_i          (nw_eff),
    .q_data_i      (pop_req),
    .q_empty_i     (q_empty),
    .q_pop_o       (pop),
    .clearing_o    (clearing),
    .valid_o       (valid_o),
    .hit_o         (hit_o),
    .set_index_o   (set_index_o),
    .tag_o         (tag_o),
    .evicted_o     (evicted_o),
    .evicted_tag_o (evicted_tag_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o)
  );

endmodule

`default_nettype wire

// File: rtl/sacfl_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// Uses sacfl_pkg for widths.
`default_nettype none

module sacfl_div import sacfl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ADDR_W-1:0] dividend_i,
  input  wire logic [BB_W-1:0]   divisor_i,
  output logic                   done_o,
  output logic [ADDR_W-1:0]      quotient_o,
  output logic [BB_W-1:0]        remainder_o
);

  logic [ADDR_W-1:0]    quo_q;
  logic [BB_W-1:0]      rem_q;
  logic [BB_W-1:0]      dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 run_q;
  logic                 done_q;

  logic [BB_W:0]   shifted;
  logic [BB_W+1:0] trial;
  logic            fits;

  always_comb begin
    shifted = {rem_q, quo_q[ADDR_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_q};
    fits    = ~trial[BB_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run_q <= 1'b0;
        end
      end
      done_q <= ~start_i & run_q & (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? trial[BB_W-1:0] : shifted[BB_W-1:0];
      quo_q <= {quo_q[ADDR_W-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// File: rtl/sacfl_front.sv
// Front end: takes an address, splits it into set and tag with the shared divider.
// Uses sacfl_pkg and sacfl_div; hands sacfl_req_t items to the queue.
`default_nettype none

module sacfl_front import sacfl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [ADDR_W-1:0] address_i,
  input  wire logic [BB_W-1:0]   block_bytes_i,
  input  wire logic [SC_W-1:0]   set_count_i,
  input  wire logic              q_full_i,
  output logic                   busy_o,
  output logic                   push_o,
  output sacfl_req_t             req_o
);

  front_state_e state_q, state_d;
  sacfl_req_t   req_q;

  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  logic [BB_W-1:0]   div_divisor;
  logic              div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [BB_W-1:0]   div_rem;

  sacfl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (accept_i) state_d = F_BLOCK;
      F_BLOCK: if (div_done) state_d = F_SET;
      F_SET:   if (div_done) state_d = F_PUSH;
      F_PUSH:  if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // first pass divides by block size, second by set count
  always_comb begin
    div_start    = 1'b0;
    div_dividend = div_quo;
    div_divisor  = {{(BB_W-SC_W){1'b0}}, set_count_i};
    push_o       = 1'b0;
    busy_o       = 1'b1;
    unique case (state_q)
      F_IDLE: begin
        busy_o       = 1'b0;
        div_start    = accept_i;
        div_dividend = address_i;
        div_divisor  = block_bytes_i;
      end
      F_BLOCK: div_start = div_done;
      F_SET:   div_start = 1'b0;
      F_PUSH:  push_o = ~q_full_i;
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_SET && div_done) begin
      req_q.set <= div_rem[SC_W-1:0];
      req_q.tag <= div_quo;
    end
  end

  assign req_o = req_q;

endmodule

`default_nettype wire

// File: rtl/sacfl_queue.sv
// Two-entry queue of classified lookups between front and back.
// Uses sacfl_pkg for the item type.
`default_nettype none

module sacfl_queue import sacfl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire sacfl_req_t push_data_i,
  input  wire logic       pop_i,
  output sacfl_req_t      pop_data_o,
  output logic            full_o,
  output logic            empty_o
);

  sacfl_req_t  ent_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o = ent_q[rd_ptr_q];
  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);

endmodule

`default_nettype wire

// File: rtl/sacfl_back.sv
// Back end: tag store and fill memories, way walk, FIFO eviction, totals and result.
// Uses sacfl_pkg; pops sacfl_req_t items from the queue.
`default_nettype none

module sacfl_back import sacfl_pkg::*; #(
  parameter int unsigned MAX_SET_COUNT = DEF_MAX_SET_COUNT,
  parameter int unsigned MAX_WAYS      = DEF_MAX_WAYS,
  localparam int unsigned FILL_W    = $clog2(MAX_WAYS + 1),
  localparam int unsigned SET_W     = (MAX_SET_COUNT > 1) ? $clog2(MAX_SET_COUNT) : 1,
  localparam int unsigned MEM_DEPTH = MAX_SET_COUNT * MAX_WAYS,
  localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [FILL_W-1:0] nw_i,
  input  wire sacfl_req_t        q_data_i,
  input  wire logic              q_empty_i,
  output logic                   q_pop_o,
  output logic                   clearing_o,
  output logic                   valid_o,
  output logic                   hit_o,
  output logic [SET_OUT_W-1:0]   set_index_o,
  output logic [TAG_W-1:0]       tag_o,
  output logic                   evicted_o,
  output logic [TAG_W-1:0]       evicted_tag_o,
  output logic [CNT_W-1:0]       hit_total_o,
  output logic [CNT_W-1:0]       miss_total_o
);

  logic [TAG_W-1:0]  tag_mem  [MEM_DEPTH];
  logic [FILL_W-1:0] fill_mem [MAX_SET_COUNT];

  back_state_e state_q, state_d;

  logic [SET_W-1:0]  clr_q;
  sacfl_req_t        req_q;
  logic [MEM_AW-1:0] base_q;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] way_q;
  logic              hit_q;
  logic              ev_q;
  logic [TAG_W-1:0]  ev_tag_q;
  logic [TAG_W-1:0]  tag_rd_q;
  logic [FILL_W-1:0] fill_rd_q;
  logic [CNT_W-1:0]  hit_cnt_q;
  logic [CNT_W-1:0]  miss_cnt_q;
  logic              res_vld_q;
  logic              res_hit_q;
  logic [SET_OUT_W-1:0] res_set_q;
  logic [TAG_W-1:0]  res_tag_q;
  logic              res_ev_q;
  logic [TAG_W-1:0]  res_ev_tag_q;
  logic [CNT_W-1:0]  res_hit_cnt_q;
  logic [CNT_W-1:0]  res_miss_cnt_q;

  logic [SET_W-1:0]  q_set;
  logic [SET_W-1:0]  req_set;
  logic [FILL_W-1:0] fill_eff;
  logic              tag_match;
  logic              last_way;
  logic              set_full;
  logic              shift_last;
  logic              clr_last;
  logic [MEM_AW-1:0] tag_raddr;

  logic              tag_we;
  logic [MEM_AW-1:0] tag_waddr;
  logic [TAG_W-1:0]  tag_wdata;
  logic              fill_we;
  logic [SET_W-1:0]  fill_waddr;
  logic [FILL_W-1:0] fill_wdata;

  always_comb begin
    q_set      = SET_W'(q_data_i.set);
    req_set    = SET_W'(req_q.set);
    fill_eff   = (fill_rd_q > nw_i) ? nw_i : fill_rd_q;
    tag_match  = (tag_rd_q == req_q.tag);
    last_way   = (way_q == fill_q - 1'b1);
    set_full   = (fill_q == nw_i);
    shift_last = (way_q == nw_i - 1'b1);
    clr_last   = (clr_q == SET_W'(MAX_SET_COUNT - 1));
    tag_raddr  = base_q + MEM_AW'(way_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR:    if (clr_last) state_d = B_IDLE;
      B_IDLE:     if (!q_empty_i) state_d = B_FILL;
      B_FILL:     state_d = (fill_eff == '0) ? B_WRITE : B_TAG_RD;
      B_TAG_RD:   state_d = B_TAG_CMP;
      B_TAG_CMP: begin
        if (tag_match) begin
          state_d = B_DONE;
        end else if (last_way) begin
          state_d = (set_full && nw_i > FILL_W'(1)) ? B_SHIFT_RD : B_WRITE;
        end else begin
          state_d = B_TAG_RD;
        end
      end
      B_SHIFT_RD: state_d = B_SHIFT_WR;
      B_SHIFT_WR: state_d = shift_last ? B_WRITE : B_SHIFT_RD;
      B_WRITE:    state_d = B_DONE;
      B_DONE:     state_d = B_IDLE;
      default:    state_d = B_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    q_pop_o    = 1'b0;
    tag_we     = 1'b0;
    tag_waddr  = base_q + MEM_AW'(way_q - 1'b1);
    tag_wdata  = tag_rd_q;
    fill_we    = 1'b0;
    fill_waddr = clr_q;
    fill_wdata = '0;
    unique case (state_q)
      B_CLEAR:    fill_we = 1'b1;
      B_IDLE:     q_pop_o = ~q_empty_i;
      B_SHIFT_WR: tag_we = 1'b1;
      B_WRITE: begin
        tag_we     = 1'b1;
        tag_waddr  = base_q + MEM_AW'(ev_q ? nw_i - 1'b1 : fill_q);
        tag_wdata  = req_q.tag;
        fill_we    = 1'b1;
        fill_waddr = req_set;
        fill_wdata = ev_q ? fill_q : fill_q + 1'b1;
      end
      default:    q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    tag_rd_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rd_q <= fill_mem[q_set];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_CLEAR;
      clr_q      <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= (state_q == B_DONE);
      if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == B_TAG_CMP && tag_match) hit_cnt_q <= hit_cnt_q + 1'b1;
      if (state_q == B_WRITE) miss_cnt_q <= miss_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        req_q  <= q_data_i;
        base_q <= MEM_AW'(q_set * MAX_WAYS);
      end
      B_FILL: begin
        fill_q <= fill_eff;
        way_q  <= '0;
        hit_q  <= 1'b0;
        ev_q   <= 1'b0;
      end
      B_TAG_CMP: begin
        if (way_q == '0) ev_tag_q <= tag_rd_q;
        if (tag_match) begin
          hit_q <= 1'b1;
        end else if (last_way) begin
          ev_q  <= set_full;
          way_q <= FILL_W'(1);
        end else begin
          way_q <= way_q + 1'b1;
        end
      end
      B_SHIFT_WR: way_q <= way_q + 1'b1;
      B_DONE: begin
        res_hit_q      <= hit_q;
        res_set_q      <= req_q.set[SET_OUT_W-1:0];
        res_tag_q      <= req_q.tag;
        res_ev_q       <= ev_q;
        res_ev_tag_q   <= ev_q ? ev_tag_q : '0;
        res_hit_cnt_q  <= hit_cnt_q;
        res_miss_cnt_q <= miss_cnt_q;
      end
      default: begin
        way_q <= way_q;
      end
    endcase
  end

  assign clearing_o    = (state_q == B_CLEAR);
  assign valid_o       = res_vld_q;
  assign hit_o         = res_hit_q;
  assign set_index_o   = res_set_q;
  assign tag_o         = res_tag_q;
  assign evicted_o     = res_ev_q;
  assign evicted_tag_o = res_ev_tag_q;
  assign hit_total_o   = res_hit_cnt_q;
  assign miss_total_o  = res_miss_cnt_q;

endmodule

`default_nettype wire

// File: tb/set_assoc_cache_fifo_lookup_core_tb.sv
// Self-checking testbench for set_assoc_cache_fifo_lookup_core: directed and random lookups.
// Predicts every lookup result from its own copy of the tag store and counters.
// Depends on sacfl_pkg and the RTL of the block.
`default_nettype none

module set_assoc_cache_fifo_lookup_core_tb;
  import sacfl_pkg::*;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 103;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned POOL_DEPTH      = 32;
  localparam int unsigned DRAIN_CYCLES    = 150;

  typedef struct packed {
    logic                 hit;
    logic [SET_OUT_W-1:0] set_index;
    logic [TAG_W-1:0]     tag;
    logic                 evicted;
    logic [TAG_W-1:0]     evicted_tag;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
  } lookup_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [ADDR_W-1:0]     address_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  valid_o;
  logic                  hit_o;
  logic [SET_OUT_W-1:0]  set_index_o;
  logic [TAG_W-1:0]      tag_o;
  logic                  evicted_o;
  logic [TAG_W-1:0]      evicted_tag_o;
  logic [CNT_W-1:0]      hit_total_o;
  logic [CNT_W-1:0]      miss_total_o;

  // Shadow of the cache: tags per set (oldest in way 0), fill per set, totals.
  logic [TAG_W-1:0]      shadow_tags [DEF_MAX_SET_COUNT][DEF_MAX_WAYS];
  int unsigned           shadow_fill [DEF_MAX_SET_COUNT];
  logic [CNT_W-1:0]      shadow_hits;
  logic [CNT_W-1:0]      shadow_misses;
  // Shadow of the register file, raw values as written.
  logic [BB_W-1:0]       reg_block_bytes;
  logic [SC_W-1:0]       reg_set_count;
  logic [WAYS_CFG_W-1:0] reg_ways;

  lookup_result_t        expected_lookups[$];
  int                    lookups_pending;
  int                    errors;
  bit                    quiet_phase;
  logic [ADDR_W-1:0]     recent_addrs [POOL_DEPTH];
  int unsigned           pool_span;

  set_assoc_cache_fifo_lookup_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .address_i     (address_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .hit_o         (hit_o),
    .set_index_o   (set_index_o),
    .tag_o         (tag_o),
    .evicted_o     (evicted_o),
    .evicted_tag_o (evicted_tag_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: one lookup against the shadow cache, updating it on a miss.
  // Zero registers act as 1; set count and ways clamp to the parameter bounds.
  // ---------------------------------------------------------------------------
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [31:0]    divisor;
    logic [31:0]    num_sets;
    logic [31:0]    num_ways;
    logic [31:0]    block_no;
    logic [31:0]    set_no;
    logic [31:0]    tag_val;
    logic [31:0]    fill;
    bit             found;
    lookup_result_t res;
    divisor  = (reg_block_bytes == '0) ? 32'd1 : 32'(reg_block_bytes);
    num_sets = (reg_set_count == '0) ? 32'd1 : 32'(reg_set_count);
    if (num_sets > DEF_MAX_SET_COUNT) num_sets = DEF_MAX_SET_COUNT;
    num_ways = (reg_ways == '0) ? 32'd1 : 32'(reg_ways);
    if (num_ways > DEF_MAX_WAYS) num_ways = DEF_MAX_WAYS;
    block_no = addr / divisor;
    set_no   = block_no % num_sets;
    tag_val  = block_no / num_sets;
    // A set filled under more ways than now configured counts as full.
    fill = shadow_fill[set_no];
    if (fill > num_ways) fill = num_ways;
    found = 1'b0;
    for (int w = 0; w < fill; w++) begin
      if (shadow_tags[set_no][w] == tag_val) found = 1'b1;
    end
    res           = '0;
    res.set_index = set_no[SET_OUT_W-1:0];
    res.tag       = tag_val;
    if (found) begin
      res.hit     = 1'b1;
      shadow_hits = shadow_hits + 1'b1;
    end else begin
      if (fill == num_ways) begin
        // FIFO eviction: drop way 0, shift down, new tag into the last way.
        res.evicted     = 1'b1;
        res.evicted_tag = shadow_tags[set_no][0];
        for (int w = 1; w < num_ways; w++) shadow_tags[set_no][w-1] = shadow_tags[set_no][w];
        shadow_tags[set_no][num_ways-1] = tag_val;
      end else begin
        shadow_tags[set_no][fill] = tag_val;
        fill++;
      end
      shadow_fill[set_no] = fill;
      shadow_misses       = shadow_misses + 1'b1;
    end
    res.hit_total  = shadow_hits;
    res.miss_total = shadow_misses;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: gaps, register writes, one lookup item.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase) return 0;
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 40);
    return $urandom_range(60, 300);
  endfunction

  // Holds until every lookup has come back and the front end is free.
  task automatic wait_idle();
    wait (lookups_pending == 0);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_BLOCK_BYTES: reg_block_bytes = data[BB_W-1:0];
      CFG_SET_COUNT:   reg_set_count   = data[SC_W-1:0];
      CFG_WAYS:        reg_ways        = data[WAYS_CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_UNMAPPED;
    cfg_data_i  = CFG_DATA_W'($urandom);
  endtask

  task automatic write_geometry(input logic [CFG_DATA_W-1:0] block_bytes,
                                input logic [CFG_DATA_W-1:0] set_count,
                                input logic [CFG_DATA_W-1:0] ways);
    wait_idle();
    write_register(CFG_BLOCK_BYTES, block_bytes);
    write_register(CFG_SET_COUNT, set_count);
    write_register(CFG_WAYS, ways);
  endtask

  // The prediction is taken at the accepting edge, before the next item.
  task automatic send_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    start_i   = 1'b1;
    address_i = addr;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_lookups.push_back(predict_lookup(addr));
    lookups_pending++;
    @(negedge clk_i);
    start_i   = 1'b0;
    address_i = $urandom;
    repeat (gap) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && valid_o) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result: expected none, got tag %h set %0d",
                 $time, tag_o, set_index_o);
        errors++;
      end else begin
        want = expected_lookups.pop_front();
        lookups_pending--;
        check_field("hit", 32'(want.hit), 32'(hit_o));
        check_field("set_index", 32'(want.set_index), 32'(set_index_o));
        check_field("tag", want.tag, tag_o);
        check_field("evicted", 32'(want.evicted), 32'(evicted_o));
        check_field("evicted_tag", want.evicted_tag, evicted_tag_o);
        check_field("hit_total", want.hit_total, hit_total_o);
        check_field("miss_total", want.miss_total, miss_total_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry is one byte per block, one set, one way: tag equals address.
  task automatic test_reset_defaults();
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_0000);
  endtask

  // Zero registers, masked upper data bits, unmapped index, values above bounds.
  task automatic test_register_limits();
    write_geometry(16'h0000, 16'hAB00, 16'hFFF0);
    send_lookup(32'h0000_0007);
    wait_idle();
    write_register(CFG_UNMAPPED, 16'hFFFF);
    send_lookup(32'h0000_0007);
    // set_count 255 clamps to 128, ways 15 clamps to 8
    write_geometry(16'hFFFF, 16'h55FF, 16'h000F);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_0000);
  endtask

  // Two-way sets: fill, hit inside a block, evict oldest, re-miss evicted tag.
  task automatic test_fifo_replacement();
    write_geometry(16'd16, 16'd4, 16'd2);
    send_lookup(32'd64);
    send_lookup(32'd128);
    send_lookup(32'd79);
    send_lookup(32'd192);
    send_lookup(32'd64);
    send_lookup(32'd48);
  endtask

  // Fill a set four deep, then drop to two ways: only ways 0..1 stay valid.
  task automatic test_ways_shrink();
    write_geometry(16'd16, 16'd4, 16'd4);
    for (int k = 10; k < 14; k++) send_lookup(32'(16 * (1 + 4 * k)));
    wait_idle();
    write_register(CFG_WAYS, 16'd2);
    send_lookup(32'(16 * (1 + 4 * 11)));
    send_lookup(32'(16 * (1 + 4 * 12)));
  endtask

  // Sets beyond a smaller set count keep their tags for later.
  task automatic test_set_shrink();
    wait_idle();
    write_register(CFG_SET_COUNT, 16'd1);
    send_lookup(32'd80);
    wait_idle();
    write_register(CFG_SET_COUNT, 16'd4);
    send_lookup(32'(16 * (1 + 4 * 12)));
  endtask

  // Mostly reuse of a small address pool so sets fill, hit and evict; the rest
  // are neighbors of pooled addresses, corner addresses and plain noise.
  function automatic logic [ADDR_W-1:0] next_address();
    int unsigned       roll;
    int unsigned       slot;
    logic [ADDR_W-1:0] addr;
    roll = $urandom_range(0, 99);
    slot = $urandom_range(0, pool_span - 1);
    if (roll < 55) return recent_addrs[slot];
    if (roll < 78) addr = recent_addrs[slot] + $urandom_range(0, 4095);
    else if (roll < 82) addr = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else addr = $urandom;
    recent_addrs[$urandom_range(0, pool_span - 1)] = addr;
    return addr;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_block_bytes();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(2, 64));
      4: return 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_set_count();
    logic [CFG_DATA_W-1:0] data;
    data = 16'($urandom);
    case ($urandom_range(0, 5))
      0: data[SC_W-1:0] = 8'd0;
      1: data[SC_W-1:0] = 8'd1;
      2: data[SC_W-1:0] = 8'd128;
      3: data[SC_W-1:0] = 8'd255;
      4: data[SC_W-1:0] = 8'($urandom_range(2, 16));
      default: data[SC_W-1:0] = 8'($urandom_range(0, 255));
    endcase
    return data;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_ways();
    logic [CFG_DATA_W-1:0] data;
    data = 16'($urandom);
    case ($urandom_range(0, 5))
      0: data[WAYS_CFG_W-1:0] = 4'd0;
      1: data[WAYS_CFG_W-1:0] = 4'd1;
      2: data[WAYS_CFG_W-1:0] = 4'd8;
      3: data[WAYS_CFG_W-1:0] = 4'd15;
      4: data[WAYS_CFG_W-1:0] = 4'($urandom_range(2, 7));
      default: data[WAYS_CFG_W-1:0] = 4'($urandom_range(0, 15));
    endcase
    return data;
  endfunction

  // Phases with fixed extreme geometry first, then extreme set count and ways with a
  // random block size, then random geometry; cache contents carry over between phases.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: write_geometry(16'd1, 16'd128, 16'd8);
        1: write_geometry(16'hFFFF, 16'd1, 16'd1);
        2: write_geometry(16'd0, 16'd0, 16'd0);
        3: write_geometry(pick_block_bytes(), 16'hFFFF, 16'hFFFF);
        default: write_geometry(pick_block_bytes(), pick_set_count(), pick_ways());
      endcase
      if ($urandom_range(0, 3) == 0) write_register(CFG_UNMAPPED, 16'($urandom));
      quiet_phase = ($urandom_range(0, 3) == 0);
      pool_span   = $urandom_range(4, POOL_DEPTH);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_lookup(next_address());
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    address_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_UNMAPPED;
    cfg_data_i      = '0;
    reg_block_bytes = 16'd1;
    reg_set_count   = 8'd1;
    reg_ways        = 4'd1;
    shadow_hits     = '0;
    shadow_misses   = '0;
    lookups_pending = 0;
    errors          = 0;
    quiet_phase     = 1'b0;
    pool_span       = POOL_DEPTH;
    for (int s = 0; s < DEF_MAX_SET_COUNT; s++) begin
      shadow_fill[s] = 0;
      for (int w = 0; w < DEF_MAX_WAYS; w++) shadow_tags[s][w] = '0;
    end
    for (int p = 0; p < POOL_DEPTH; p++) recent_addrs[p] = $urandom;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_register_limits();
    test_fifo_replacement();
    test_ways_shrink();
    test_set_shrink();
    test_random_traffic();

    // Drain, then keep watching for stray strobes before the end.
    wait (lookups_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("set_assoc_cache_fifo_lookup_core_tb passed");
    end else begin
      $display("set_assoc_cache_fifo_lookup_core_tb failed");
    end
    $finish;
  end

  // The run covers roughly 1050 items; this limit is several times their
  // worst-case run time.
  initial begin
    #30_000_000;
    $display("set_assoc_cache_fifo_lookup_core_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/sacfl_pkg.sv
rtl/sacfl_div.sv
rtl/sacfl_front.sv
rtl/sacfl_queue.sv
rtl/sacfl_back.sv
rtl/set_assoc_cache_fifo_lookup_core.sv
tb/set_assoc_cache_fifo_lookup_core_tb.sv
